@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication violated");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle implication violated");

`endif

@@ sv/oaids_pkg.sv @@
// ----------------------------------------------------------------------------
// oaids_pkg
// command, status and cell operation codes for the ordered array core
// ----------------------------------------------------------------------------
package oaids_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 5;
    localparam int CAP_W  = 5;
    localparam int IDX_W  = 4;

    // commands
    localparam logic [2:0] CMD_READ      = 3'd0;
    localparam logic [2:0] CMD_INS_AT    = 3'd1;
    localparam logic [2:0] CMD_INS_LAST  = 3'd2;
    localparam logic [2:0] CMD_DEL_AT    = 3'd3;
    localparam logic [2:0] CMD_DEL_LAST  = 3'd4;
    localparam logic [2:0] CMD_SORT      = 3'd5;
    localparam logic [2:0] CMD_SEARCH    = 3'd6;
    localparam logic [2:0] CMD_CLEAR     = 3'd7;

    // result status
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_FULL     = 3'd1;
    localparam logic [2:0] STAT_EMPTY    = 3'd2;
    localparam logic [2:0] STAT_BADIDX   = 3'd3;
    localparam logic [2:0] STAT_NOTFOUND = 3'd4;

    // per-cell operations
    localparam logic [2:0] OP_HOLD    = 3'd0;
    localparam logic [2:0] OP_LOAD    = 3'd1;
    localparam logic [2:0] OP_SHL     = 3'd2;
    localparam logic [2:0] OP_SHR     = 3'd3;
    localparam logic [2:0] OP_SORT_LO = 3'd4;
    localparam logic [2:0] OP_SORT_HI = 3'd5;

    // per-cell control: operation plus broadcast word (insert value or key)
    typedef struct packed {
        logic [2:0]        op;
        logic [WORD_W-1:0] data;
    } cell_ctl_t;

endpackage

@@ sv/oaids_cell.sv @@
// ----------------------------------------------------------------------------
// oaids_cell
// one slot of the array: holds a word, shifts, loads or compare-swaps
// ----------------------------------------------------------------------------
module oaids_cell
(
    input  logic                              clk,
    input  oaids_pkg::cell_ctl_t              ctl,
    input  logic [oaids_pkg::WORD_W-1:0]      left_word,
    input  logic [oaids_pkg::WORD_W-1:0]      right_word,
    input  logic                              left_gt,
    output logic [oaids_pkg::WORD_W-1:0]      word,
    output logic                              gt_right,
    output logic                              match
);

    logic [oaids_pkg::WORD_W-1:0] word_reg;
    logic [oaids_pkg::WORD_W-1:0] word_next;

    assign gt_right = $signed(word_reg) > $signed(right_word);
    assign match    = (word_reg == ctl.data);
    assign word     = word_reg;

    always_comb
    begin
        case (ctl.op)
            oaids_pkg::OP_HOLD:    word_next = word_reg;
            oaids_pkg::OP_LOAD:    word_next = ctl.data;
            oaids_pkg::OP_SHL:     word_next = left_word;
            oaids_pkg::OP_SHR:     word_next = right_word;
            oaids_pkg::OP_SORT_LO: word_next = gt_right ? right_word : word_reg;
            oaids_pkg::OP_SORT_HI: word_next = left_gt ? left_word : word_reg;
            default:               word_next = word_reg;
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

@@ sv/ordered_array_insert_delete_sort_search_core.sv @@
// ----------------------------------------------------------------------------
// ordered_array_insert_delete_sort_search_core
// bounded array of signed words in a row of cells, with indexed insert,
// delete, read, sort, search and clear commands
// ----------------------------------------------------------------------------
// usage
//   s_* carries one command per transfer, m_* returns exactly one result per
//   command, in order. capacity is set over the apb port while idle.
//   read, insert, delete and clear finish in the accept cycle: the result
//   is in the output register in the cycle after the command transfer.
//   sort runs odd-even transposition over the cell row, one phase per cycle,
//   count phases, then writes its result once the output register is free.
//   search walks the cells' match flags one position per cycle until a
//   match or the end of the entries. one command is in flight at a time.
//   the output register is separate from the cell row: a new command is
//   taken while a result waits as long as the register drains in the same
//   cycle; when m_tready stays low the finished result holds and s_tready
//   drops until the result is taken.
//   reset clears the count, capacity goes to 16, the stored words keep
//   whatever they held and are never read before being written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_array_insert_delete_sort_search_core
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,

    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // cmd[2:0], value[34:3], index[38:35], zero pad

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // status[2:0], read_value[34:3],
                                    // found_index[38:35], count_now[43:39], pad

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WW = oaids_pkg::WORD_W;
    localparam int CW = oaids_pkg::CNT_W;
    // position width: holds DEPTH and any count
    localparam int PW = ($clog2(DEPTH + 1) > CW) ? $clog2(DEPTH + 1) : CW;
    localparam int AW = $clog2(DEPTH);
    localparam logic [PW-1:0] DEPTH_W = PW'(DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SORT   = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [oaids_pkg::CAP_W-1:0] cap_reg;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(cap_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= oaids_pkg::CAP_W'(16);
        else if (psel && penable && pwrite && pready && !paddr[2])
            cap_reg <= pwdata[oaids_pkg::CAP_W-1:0];
    end

    // ------------------------------------------------------------------
    // command fields
    // ------------------------------------------------------------------
    logic [2:0]                   in_cmd;
    logic [WW-1:0]                in_value;
    logic [oaids_pkg::IDX_W-1:0]  in_index;
    logic [PW-1:0]                idx_ext;

    assign in_cmd   = s_tdata[2:0];
    assign in_value = s_tdata[34:3];
    assign in_index = s_tdata[38:35];
    assign idx_ext  = PW'(in_index);

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    logic [1:0]    state_reg,  state_next;
    logic [CW-1:0] cnt_reg,    cnt_next;
    logic [PW-1:0] pass_reg,   pass_next;   // sort phase count / search position
    logic          phase_reg,  phase_next;
    logic [WW-1:0] key_reg,    key_next;

    logic          ovld_reg,   ovld_next;
    logic [2:0]    ostat_reg,  ostat_next;
    logic [WW-1:0] orv_reg,    orv_next;
    logic [3:0]    ofound_reg, ofound_next;
    logic [CW-1:0] ocnt_reg,   ocnt_next;

    logic [PW-1:0] cnt_ext;
    logic [PW-1:0] cap_ext;
    logic [PW-1:0] limit;
    logic          is_full;
    logic          slot_free;
    logic          accept;

    // cell row signals
    oaids_pkg::cell_ctl_t ctl   [DEPTH];
    logic [WW-1:0]        words [DEPTH];
    logic [DEPTH-1:0]     gt;
    logic [DEPTH-1:0]     match;

    // shift / sort controls shared by all cells
    logic          ins_en;
    logic          del_en;
    logic          sort_en;
    logic [PW-1:0] op_pos;
    logic [WW-1:0] rd_word;
    logic          match_sel;

    assign cnt_ext   = PW'(cnt_reg);
    assign cap_ext   = PW'(cap_reg);
    assign limit     = (cap_ext > DEPTH_W) ? DEPTH_W : cap_ext;
    assign is_full   = (cnt_ext >= limit);
    assign slot_free = !ovld_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;

    // indexed read: index port only reaches the first 16 cells
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (PW'(i) == idx_ext)
                rd_word = words[i];
        end
    end

    assign match_sel = (pass_reg < cnt_ext) && match[pass_reg[AW-1:0]];

    // ------------------------------------------------------------------
    // command sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pass_next   = pass_reg;
        phase_next  = phase_reg;
        key_next    = key_reg;
        ins_en      = 1'b0;
        del_en      = 1'b0;
        sort_en     = 1'b0;
        op_pos      = idx_ext;

        ovld_next   = ovld_reg && !m_tready;
        ostat_next  = ostat_reg;
        orv_next    = orv_reg;
        ofound_next = ofound_reg;
        ocnt_next   = ocnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ostat_next  = oaids_pkg::STAT_OK;
                    orv_next    = '0;
                    ofound_next = '0;
                    ovld_next   = 1'b1;
                    case (in_cmd)
                        oaids_pkg::CMD_READ:
                        begin
                            if (cnt_reg == '0)
                                ostat_next = oaids_pkg::STAT_EMPTY;
                            else if (idx_ext >= cnt_ext)
                                ostat_next = oaids_pkg::STAT_BADIDX;
                            else
                                orv_next = rd_word;
                        end
                        oaids_pkg::CMD_INS_AT:
                        begin
                            if (is_full)
                                ostat_next = oaids_pkg::STAT_FULL;
                            else if (idx_ext > cnt_ext)
                                ostat_next = oaids_pkg::STAT_BADIDX;
                            else
                            begin
                                ins_en   = 1'b1;
                                cnt_next = CW'(cnt_ext + PW'(1));
                            end
                        end
                        oaids_pkg::CMD_INS_LAST:
                        begin
                            op_pos = cnt_ext;
                            if (is_full)
                                ostat_next = oaids_pkg::STAT_FULL;
                            else
                            begin
                                ins_en   = 1'b1;
                                cnt_next = CW'(cnt_ext + PW'(1));
                            end
                        end
                        oaids_pkg::CMD_DEL_AT:
                        begin
                            if (cnt_reg == '0)
                                ostat_next = oaids_pkg::STAT_EMPTY;
                            else if (idx_ext >= cnt_ext)
                                ostat_next = oaids_pkg::STAT_BADIDX;
                            else
                            begin
                                del_en   = 1'b1;
                                cnt_next = cnt_reg - CW'(1);
                            end
                        end
                        oaids_pkg::CMD_DEL_LAST:
                        begin
                            if (cnt_reg == '0)
                                ostat_next = oaids_pkg::STAT_EMPTY;
                            else
                                cnt_next = cnt_reg - CW'(1);
                        end
                        oaids_pkg::CMD_SORT:
                        begin
                            ovld_next  = ovld_reg && !m_tready;
                            pass_next  = '0;
                            phase_next = 1'b0;
                            state_next = S_SORT;
                        end
                        oaids_pkg::CMD_SEARCH:
                        begin
                            ovld_next  = ovld_reg && !m_tready;
                            pass_next  = '0;
                            key_next   = in_value;
                            state_next = S_SEARCH;
                        end
                        oaids_pkg::CMD_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        default:
                        begin
                            cnt_next = cnt_reg;
                        end
                    endcase
                    ocnt_next = cnt_next;
                end
            end

            S_SORT:
            begin
                if (pass_reg < cnt_ext)
                begin
                    sort_en    = 1'b1;
                    pass_next  = pass_reg + PW'(1);
                    phase_next = !phase_reg;
                end
                else if (slot_free)
                begin
                    ovld_next   = 1'b1;
                    ostat_next  = oaids_pkg::STAT_OK;
                    orv_next    = '0;
                    ofound_next = '0;
                    ocnt_next   = cnt_reg;
                    state_next  = S_IDLE;
                end
            end

            S_SEARCH:
            begin
                if (match_sel || (pass_reg >= cnt_ext))
                begin
                    if (slot_free)
                    begin
                        ovld_next   = 1'b1;
                        ostat_next  = match_sel ? oaids_pkg::STAT_OK
                                                : oaids_pkg::STAT_NOTFOUND;
                        orv_next    = '0;
                        ofound_next = match_sel ? pass_reg[3:0] : 4'd0;
                        ocnt_next   = cnt_reg;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    pass_next = pass_reg + PW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pass_reg  <= '0;
            phase_reg <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pass_reg  <= pass_next;
            phase_reg <= phase_next;
            ovld_reg  <= ovld_next;
        end
    end

    // result payload and search key, no reset
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        ostat_reg  <= ostat_next;
        orv_reg    <= orv_next;
        ofound_reg <= ofound_next;
        ocnt_reg   <= ocnt_next;
    end

    assign m_tvalid = ovld_reg;
    assign m_tdata  = {4'd0, ocnt_reg, ofound_reg, orv_reg, ostat_reg};

    // ------------------------------------------------------------------
    // cell row
    // ------------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [PW-1:0] POS    = PW'(i);
        localparam logic [PW-1:0] POS_P1 = PW'(i + 1);

        logic [WW-1:0] left_w;
        logic [WW-1:0] right_w;
        logic          left_g;

        if (i == 0)
        begin : g_first
            assign left_w = words[i];
            assign left_g = 1'b0;
        end
        else
        begin : g_mid
            assign left_w = words[i-1];
            assign left_g = gt[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = words[i];
        end
        else
        begin : g_inner
            assign right_w = words[i+1];
        end

        always_comb
        begin
            ctl[i].op   = oaids_pkg::OP_HOLD;
            ctl[i].data = accept ? in_value : key_reg;
            if (ins_en)
            begin
                if (POS == op_pos)
                    ctl[i].op = oaids_pkg::OP_LOAD;
                else if ((POS > op_pos) && (POS <= cnt_ext))
                    ctl[i].op = oaids_pkg::OP_SHL;
            end
            else if (del_en)
            begin
                if ((POS >= op_pos) && (POS_P1 < cnt_ext))
                    ctl[i].op = oaids_pkg::OP_SHR;
            end
            else if (sort_en)
            begin
                // pairs start at even or odd positions on alternate phases
                if ((POS[0] == phase_reg) && (POS_P1 < cnt_ext))
                    ctl[i].op = oaids_pkg::OP_SORT_LO;
                else if ((POS[0] != phase_reg) && (i != 0) && (POS < cnt_ext))
                    ctl[i].op = oaids_pkg::OP_SORT_HI;
            end
        end

        oaids_cell u_cell
        (
            .clk        (clk),
            .ctl        (ctl[i]),
            .left_word  (left_w),
            .right_word (right_w),
            .left_gt    (left_g),
            .word       (words[i]),
            .gt_right   (gt[i]),
            .match      (match[i])
        );
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_count_in_depth, cnt_ext <= DEPTH_W)
    `ASSERT_NEXT(a_count_stable_busy, state_reg != S_IDLE, cnt_reg == $past(cnt_reg))
    `ASSERT_IMPLIES(a_sorted_head, (state_reg == S_SORT) && (pass_reg >= cnt_ext) && (cnt_ext >= PW'(2)), $signed(words[0]) <= $signed(words[1]))

endmodule

@@ verif/tb_ordered_array_insert_delete_sort_search_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_array_insert_delete_sort_search_core
// self-checking bench for the ordered array core: a queue-fed command driver,
// a result monitor and a shadow copy of the array that predicts every result,
// run through several capacity settings and several idle/stall patterns
// ----------------------------------------------------------------------------
module tb_ordered_array_insert_delete_sort_search_core;

    localparam int ARRAY_DEPTH = 16;
    localparam int DRAIN_GAP   = ARRAY_DEPTH + 4;   // longest sort or search plus margin
    localparam int NUM_PHASES  = 8;

    // capacity register address on the apb port
    localparam logic [2:0] ADDR_CAPACITY = 3'd0;

    typedef struct {
        logic [2:0]         cmd;
        logic signed [31:0] value;
        logic [3:0]         index;
    } array_cmd_t;

    typedef struct {
        logic [2:0]         status;
        logic signed [31:0] read_value;
        logic [3:0]         found_index;
        logic [4:0]         count_now;
    } array_rsp_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // dut inputs, known from time zero
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata  = '0;     // cmd[2:0], value[34:3], index[38:35], zero pad
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;

    // dut outputs
    logic        s_tready;
    logic        m_tvalid;
    logic [47:0] m_tdata;           // status[2:0], read_value[34:3],
                                    // found_index[38:35], count_now[43:39], pad
    logic [31:0] prdata;
    logic        pready;

    // commands waiting for the driver, and results owed by the dut
    array_cmd_t pending_cmds[$];
    array_rsp_t response_due[$];
    array_cmd_t cmd_on_bus;
    array_rsp_t want_rsp;
    array_rsp_t got_rsp;

    // shadow copy of the array state
    logic signed [31:0] shadow_word [ARRAY_DEPTH];
    int                 shadow_len = 0;
    int                 shadow_cap = 16;

    // idle and stall odds, in percent, changed only between phases
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int fail_cnt      = 0;

    // phase plan: capacity, sender idle, receiver stall, random command count
    int phase_cap   [NUM_PHASES] = '{16,  4,  1,  0, 31, 16,  9, 20};
    int phase_idle  [NUM_PHASES] = '{ 0, 76,  0, 28,  0, 76,  0, 28};
    int phase_stall [NUM_PHASES] = '{ 0,  0, 76, 28,  0,  0, 76, 28};
    int phase_items [NUM_PHASES] = '{150, 130, 110, 40, 150, 150, 160, 160};

    ordered_array_insert_delete_sort_search_core #(
        .DEPTH (ARRAY_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // shadow array
    // ------------------------------------------------------------------------

    // open a slot at pos, moving the tail up by one
    function automatic void shadow_insert(input int pos, input logic signed [31:0] v);
        for (int i = shadow_len; i > pos; i--)
            shadow_word[i] = shadow_word[i-1];
        shadow_word[pos] = v;
        shadow_len++;
    endfunction

    // apply one command to the shadow array and return the result it owes
    function automatic array_rsp_t apply_array_cmd(input array_cmd_t c);
        array_rsp_t         r;
        int                 limit;
        logic signed [31:0] tmp;
        r.status      = oaids_pkg::STAT_OK;
        r.read_value  = '0;
        r.found_index = '0;
        // capacity above the built depth saturates
        limit = (shadow_cap > ARRAY_DEPTH) ? ARRAY_DEPTH : shadow_cap;
        case (c.cmd)
            oaids_pkg::CMD_READ:
            begin
                if (shadow_len == 0)
                    r.status = oaids_pkg::STAT_EMPTY;
                else if (int'(c.index) >= shadow_len)
                    r.status = oaids_pkg::STAT_BADIDX;
                else
                    r.read_value = shadow_word[c.index];
            end
            oaids_pkg::CMD_INS_AT:
            begin
                // full is checked ahead of the index; index == length appends
                if (shadow_len >= limit)
                    r.status = oaids_pkg::STAT_FULL;
                else if (int'(c.index) > shadow_len)
                    r.status = oaids_pkg::STAT_BADIDX;
                else
                    shadow_insert(int'(c.index), c.value);
            end
            oaids_pkg::CMD_INS_LAST:
            begin
                if (shadow_len >= limit)
                    r.status = oaids_pkg::STAT_FULL;
                else
                    shadow_insert(shadow_len, c.value);
            end
            oaids_pkg::CMD_DEL_AT:
            begin
                if (shadow_len == 0)
                    r.status = oaids_pkg::STAT_EMPTY;
                else if (int'(c.index) >= shadow_len)
                    r.status = oaids_pkg::STAT_BADIDX;
                else
                begin
                    for (int i = int'(c.index); i + 1 < shadow_len; i++)
                        shadow_word[i] = shadow_word[i+1];
                    shadow_len--;
                end
            end
            oaids_pkg::CMD_DEL_LAST:
            begin
                if (shadow_len == 0)
                    r.status = oaids_pkg::STAT_EMPTY;
                else
                    shadow_len--;
            end
            oaids_pkg::CMD_SORT:
            begin
                // ascending signed order over the used entries
                for (int i = 0; i < shadow_len - 1; i++)
                    for (int j = 0; j < shadow_len - 1 - i; j++)
                        if (shadow_word[j] > shadow_word[j+1])
                        begin
                            tmp              = shadow_word[j];
                            shadow_word[j]   = shadow_word[j+1];
                            shadow_word[j+1] = tmp;
                        end
            end
            oaids_pkg::CMD_SEARCH:
            begin
                // lowest matching index wins
                r.status = oaids_pkg::STAT_NOTFOUND;
                for (int i = 0; i < shadow_len; i++)
                    if (r.status != oaids_pkg::STAT_OK && shadow_word[i] == c.value)
                    begin
                        r.status      = oaids_pkg::STAT_OK;
                        r.found_index = i[3:0];
                    end
            end
            oaids_pkg::CMD_CLEAR:
            begin
                // stored words stay, only the length drops
                shadow_len = 0;
            end
            default:
            begin
                shadow_len = shadow_len;
            end
        endcase
        r.count_now = shadow_len[4:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void push_cmd(input logic [2:0] cmd, input logic signed [31:0] value,
                                     input logic [3:0] index);
        array_cmd_t c;
        c.cmd   = cmd;
        c.value = value;
        c.index = index;
        pending_cmds.push_back(c);
    endfunction

    // values drawn often from a small pool so searches hit and duplicates occur
    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(99) < 45)
            return $urandom;
        case ($urandom_range(7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sd0;
            3:       return -32'sd1;
            4:       return 32'sd1;
            5:       return 32'sd7;
            6:       return -32'sd7;
            default: return 32'sd100;
        endcase
    endfunction

    // inserts outweigh deletes so the array fills up and hits its capacity
    function automatic void push_random_cmd();
        int         pick;
        logic [2:0] cmd;
        logic [3:0] index;
        pick = $urandom_range(99);
        if (pick < 14)
            cmd = oaids_pkg::CMD_READ;
        else if (pick < 34)
            cmd = oaids_pkg::CMD_INS_AT;
        else if (pick < 52)
            cmd = oaids_pkg::CMD_INS_LAST;
        else if (pick < 64)
            cmd = oaids_pkg::CMD_DEL_AT;
        else if (pick < 72)
            cmd = oaids_pkg::CMD_DEL_LAST;
        else if (pick < 78)
            cmd = oaids_pkg::CMD_SORT;
        else if (pick < 96)
            cmd = oaids_pkg::CMD_SEARCH;
        else
            cmd = oaids_pkg::CMD_CLEAR;
        // keep a share of small indexes so short arrays see valid positions
        index = ($urandom_range(1) == 0) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
        push_cmd(cmd, pick_value(), index);
    endfunction

    // capacity write, then read it back over apb
    task automatic write_capacity(input logic [31:0] cap);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CAPACITY;
        pwdata  <= cap;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // register is written at this edge
        shadow_cap = int'(cap[4:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {27'd0, cap[4:0]})
        begin
            $error("prdata expected %0d actual %0d", cap[4:0], prdata);
            fail_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_tvalid || response_due.size() != 0)
            @(posedge clk);
        // sort or search may still be running on a late result
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // command driver: pops the queue, predicts on every transfer
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                response_due.push_back(apply_array_cmd(cmd_on_bus));
            // load the next command once the bus is free
            if (!s_tvalid || s_tready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    cmd_on_bus = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, cmd_on_bus.index, cmd_on_bus.value, cmd_on_bus.cmd};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: field-by-field compare against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_rsp.status      = m_tdata[2:0];
                got_rsp.read_value  = m_tdata[34:3];
                got_rsp.found_index = m_tdata[38:35];
                got_rsp.count_now   = m_tdata[43:39];
                if (response_due.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    fail_cnt++;
                end
                else
                begin
                    want_rsp = response_due.pop_front();
                    if (got_rsp.status !== want_rsp.status)
                    begin
                        $error("status expected %0d actual %0d",
                               want_rsp.status, got_rsp.status);
                        fail_cnt++;
                    end
                    if (got_rsp.read_value !== want_rsp.read_value)
                    begin
                        $error("read_value expected %0d actual %0d",
                               want_rsp.read_value, got_rsp.read_value);
                        fail_cnt++;
                    end
                    if (got_rsp.found_index !== want_rsp.found_index)
                    begin
                        $error("found_index expected %0d actual %0d",
                               want_rsp.found_index, got_rsp.found_index);
                        fail_cnt++;
                    end
                    if (got_rsp.count_now !== want_rsp.count_now)
                    begin
                        $error("count_now expected %0d actual %0d",
                               want_rsp.count_now, got_rsp.count_now);
                        fail_cnt++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // phase sequencer
    // ------------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < ARRAY_DEPTH; i++)
            shadow_word[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // capacity changes only with the core idle; lowering it below
            // the current length keeps the entries
            write_capacity(phase_cap[p]);
            src_idle_pct  = phase_idle[p];
            snk_stall_pct = phase_stall[p];

            if (p == 0)
            begin
                // empty array: every command that needs an entry
                push_cmd(oaids_pkg::CMD_READ,     32'sd5,          4'd0);
                push_cmd(oaids_pkg::CMD_DEL_AT,   32'sd5,          4'd0);
                push_cmd(oaids_pkg::CMD_DEL_LAST, 32'sd5,          4'd0);
                push_cmd(oaids_pkg::CMD_SEARCH,   32'sd0,          4'd0);
                push_cmd(oaids_pkg::CMD_SORT,     32'sd0,          4'd0);
                // single entry sort is a no-op
                push_cmd(oaids_pkg::CMD_INS_LAST, 32'sh7fff_ffff,  4'd15);
                push_cmd(oaids_pkg::CMD_SORT,     32'sd0,          4'd0);
                push_cmd(oaids_pkg::CMD_INS_AT,   32'sh8000_0000,  4'd0);
                // insert past the length, then exactly at it
                push_cmd(oaids_pkg::CMD_INS_AT,   32'sd9,          4'd5);
                push_cmd(oaids_pkg::CMD_INS_AT,   -32'sd1,         4'd2);
                push_cmd(oaids_pkg::CMD_INS_AT,   32'sd0,          4'd1);
                push_cmd(oaids_pkg::CMD_INS_LAST, -32'sd1,         4'd0);
                push_cmd(oaids_pkg::CMD_READ,     32'sd0,          4'd3);
                push_cmd(oaids_pkg::CMD_READ,     32'sd0,          4'd15);
                // duplicate key: lowest index reported
                push_cmd(oaids_pkg::CMD_SEARCH,   -32'sd1,         4'd0);
                push_cmd(oaids_pkg::CMD_SEARCH,   32'sd12345,      4'd0);
                push_cmd(oaids_pkg::CMD_SORT,     32'sd0,          4'd0);
                push_cmd(oaids_pkg::CMD_READ,     32'sd0,          4'd0);
                push_cmd(oaids_pkg::CMD_READ,     32'sd0,          4'd4);
                push_cmd(oaids_pkg::CMD_DEL_AT,   32'sd0,          4'd1);
                push_cmd(oaids_pkg::CMD_DEL_AT,   32'sd0,          4'd15);
                push_cmd(oaids_pkg::CMD_DEL_LAST, 32'sd0,          4'd0);
                push_cmd(oaids_pkg::CMD_CLEAR,    32'sd0,          4'd0);
                push_cmd(oaids_pkg::CMD_READ,     32'sd0,          4'd0);
            end

            for (int n = 0; n < phase_items[p]; n++)
                push_random_cmd();

            wait_drained();
        end

        if (fail_cnt == 0 && response_due.size() == 0)
            $display("tb_ordered_array_insert_delete_sort_search_core OK");
        else
            $display("tb_ordered_array_insert_delete_sort_search_core NOT OK");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial
    begin
        #2_000_000;
        $display("tb_ordered_array_insert_delete_sort_search_core NOT OK");
        $finish;
    end

endmodule
